// ===== hw/rtl/neighborhood_blend_smoother_macros.svh =====
// Assertion macros used by the smoother RTL.
`ifndef NEIGHBORHOOD_BLEND_SMOOTHER_MACROS_SVH
`define NEIGHBORHOOD_BLEND_SMOOTHER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checks a property on every clock edge outside reset.
`define NBS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition is followed by a consequence in the same cycle.
`define NBS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`else

`define NBS_ASSERT(lbl, prop, msg)
`define NBS_ASSERT_IMPL(lbl, ante, cons, msg)

`endif

`endif

// ===== hw/rtl/nbs_pkg.sv =====
// Package with the constants, types and tables of the neighborhood smoother.
`timescale 1ns / 1ps

package nbs_pkg;

  localparam int MAX_DIM     = 128;
  localparam int DIM_BITS    = $clog2(MAX_DIM);
  localparam int HEIGHT_BITS = 16;
  localparam int DEPTH       = MAX_DIM * MAX_DIM;
  localparam int ADDR_BITS   = 2 * DIM_BITS;

  // Field widths of the ports.
  localparam int COORD_BITS = 7;
  localparam int OUT_BITS   = 16;
  localparam int CNT_BITS   = 4;
  localparam int STR_BITS   = 9;
  localparam int GRID_BITS  = 8;
  localparam int PADDR_BITS = 4;
  localparam int PDATA_BITS = 32;

  // A sum of nine heights needs four more bits than one height.
  localparam int SUM_BITS    = HEIGHT_BITS + 4;
  localparam int RECIP_SHIFT = 24;
  localparam int RECIP_BITS  = RECIP_SHIFT + 1;
  localparam int PROD_BITS   = SUM_BITS + RECIP_BITS;
  localparam int BLEND_BITS  = HEIGHT_BITS + STR_BITS;
  localparam int BLEND_SHIFT = 8;

  localparam logic [STR_BITS-1:0]  FULL_SCALE    = 9'd256;
  localparam logic [STR_BITS-1:0]  STR_RESET     = 9'd128;
  localparam logic [GRID_BITS-1:0] GRID_MAX      = GRID_BITS'(MAX_DIM);
  localparam logic [CNT_BITS-1:0]  MAX_NEIGHBORS = 4'd9;

  // Operation codes.
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Register indexes, taken from paddr[3:2].
  localparam logic [1:0] REG_STRENGTH    = 2'd0;
  localparam logic [1:0] REG_GRID_WIDTH  = 2'd1;
  localparam logic [1:0] REG_GRID_HEIGHT = 2'd2;

  // Query command from the top level to the gather sequencer.
  typedef struct packed {
    logic                  start;
    logic [COORD_BITS-1:0] col;
    logic [COORD_BITS-1:0] row;
  } gth_cmd_t;

  // Accumulated neighborhood handed from the gather sequencer to the blend pipe.
  typedef struct packed {
    logic                   valid;
    logic                   oor;
    logic [SUM_BITS-1:0]    sum;
    logic [CNT_BITS-1:0]    count;
    logic [HEIGHT_BITS-1:0] center;
  } gth_res_t;

  // ceil(2^RECIP_SHIFT / count); exact floor division for any sum below 2^20.
  function automatic logic [RECIP_BITS-1:0] recip(input logic [CNT_BITS-1:0] count);
    logic [RECIP_BITS-1:0] r;
    unique case (count)
      4'd1:    r = 25'd16777216;
      4'd2:    r = 25'd8388608;
      4'd3:    r = 25'd5592406;
      4'd4:    r = 25'd4194304;
      4'd5:    r = 25'd3355444;
      4'd6:    r = 25'd2796203;
      4'd7:    r = 25'd2396746;
      4'd8:    r = 25'd2097152;
      4'd9:    r = 25'd1864136;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/nbs_height_ram.sv =====
// Single-port synchronous RAM with a registered read.
`timescale 1ns / 1ps

module nbs_height_ram #(
  parameter int Depth = 16384,
  parameter int Width = 16
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/nbs_gather.sv =====
// Sequencer that reads a 3x3 neighborhood from the height RAM and sums it.
`timescale 1ns / 1ps
`include "neighborhood_blend_smoother_macros.svh"

module nbs_gather import nbs_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  gth_cmd_t               cmd_i,
  input  logic [GRID_BITS-1:0]   gw_i,
  input  logic [GRID_BITS-1:0]   gh_i,
  output logic                   ram_re_o,
  output logic [ADDR_BITS-1:0]   ram_addr_o,
  input  logic [HEIGHT_BITS-1:0] ram_rdata_i,
  output gth_res_t               res_o,
  output logic                   busy_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  logic                   state_q, state_d;
  logic [1:0]             dc_q, dc_d, dr_q, dr_d;
  logic [COORD_BITS-1:0]  col_q, row_q;
  logic                   rd_valid_q, rd_center_q, last_q;
  logic                   done_q, done_d;
  logic                   oor_q;
  logic [SUM_BITS-1:0]    sum_q;
  logic [CNT_BITS-1:0]    count_q;
  logic [HEIGHT_BITS-1:0] center_q;

  logic                   cmd_oor;
  logic [GRID_BITS-1:0]   vcol, vrow, ncol, nrow;
  logic                   in_grid, issue_last;

  assign cmd_oor = ({1'b0, cmd_i.col} >= gw_i) || ({1'b0, cmd_i.row} >= gh_i);

  // Neighbor coordinate plus one, so that the column left of zero is zero.
  assign vcol    = GRID_BITS'(col_q) + GRID_BITS'(dc_q);
  assign vrow    = GRID_BITS'(row_q) + GRID_BITS'(dr_q);
  assign ncol    = vcol - 8'd1;
  assign nrow    = vrow - 8'd1;
  assign in_grid = (vcol != '0) && (vcol <= gw_i) && (vrow != '0) && (vrow <= gh_i);

  assign issue_last = (dc_q == 2'd2) && (dr_q == 2'd2);
  assign ram_re_o   = (state_q == ST_READ) && in_grid;
  assign ram_addr_o = {nrow[DIM_BITS-1:0], ncol[DIM_BITS-1:0]};

  always_comb begin
    state_d = state_q;
    dc_d    = dc_q;
    dr_d    = dr_q;
    unique case (state_q)
      ST_IDLE: begin
        dc_d = 2'd0;
        dr_d = 2'd0;
        if (cmd_i.start && !cmd_oor) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        if (dc_q == 2'd2) begin
          dc_d = 2'd0;
          dr_d = dr_q + 2'd1;
        end else begin
          dc_d = dc_q + 2'd1;
        end
        if (issue_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign done_d = (cmd_i.start && cmd_oor) || last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      dc_q        <= 2'd0;
      dr_q        <= 2'd0;
      rd_valid_q  <= 1'b0;
      rd_center_q <= 1'b0;
      last_q      <= 1'b0;
      done_q      <= 1'b0;
      count_q     <= '0;
    end else begin
      state_q     <= state_d;
      dc_q        <= dc_d;
      dr_q        <= dr_d;
      rd_valid_q  <= ram_re_o;
      rd_center_q <= (state_q == ST_READ) && (dc_q == 2'd1) && (dr_q == 2'd1);
      last_q      <= (state_q == ST_READ) && issue_last;
      done_q      <= done_d;
      if (cmd_i.start) begin
        count_q <= '0;
      end else if (rd_valid_q) begin
        count_q <= count_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      col_q <= cmd_i.col;
      row_q <= cmd_i.row;
      oor_q <= cmd_oor;
      sum_q <= '0;
    end else if (rd_valid_q) begin
      sum_q <= sum_q + SUM_BITS'(ram_rdata_i);
    end
    if (rd_center_q) begin
      center_q <= ram_rdata_i;
    end
  end

  assign res_o.valid  = done_q;
  assign res_o.oor    = oor_q;
  assign res_o.sum    = sum_q;
  assign res_o.count  = count_q;
  assign res_o.center = center_q;

  assign busy_o = (state_q == ST_READ) || rd_valid_q || last_q || done_q;

  `NBS_ASSERT(a_count_max, count_q <= MAX_NEIGHBORS, "neighbor count above nine")
  `NBS_ASSERT(a_done_pulse, done_q |=> !done_q, "gather result held for two cycles")
  `NBS_ASSERT(a_last_done, last_q |=> done_q, "last read did not finish the query")
  `NBS_ASSERT_IMPL(a_start_idle, cmd_i.start, state_q == ST_IDLE && !done_q,
                   "query started while the sequencer was busy")

endmodule

// ===== hw/rtl/nbs_blend.sv =====
// Two-stage pipe that divides the neighborhood sum and blends it with the center.
`timescale 1ns / 1ps

module nbs_blend import nbs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  gth_res_t            res_i,
  input  logic [STR_BITS-1:0] strength_i,
  output logic                busy_o,
  output logic                valid_o,
  output logic [OUT_BITS-1:0] height_o,
  output logic [CNT_BITS-1:0] count_o,
  output logic                oor_o
);

  logic                   s1_valid_q, valid_q;
  logic                   s1_oor_q, oor_q;
  logic [PROD_BITS-1:0]   s1_prod_q;
  logic [HEIGHT_BITS-1:0] s1_center_q;
  logic [CNT_BITS-1:0]    s1_count_q, count_q;
  logic [OUT_BITS-1:0]    height_q;

  logic [HEIGHT_BITS-1:0] avg;
  logic [BLEND_BITS-1:0]  blend;

  assign avg   = s1_prod_q[RECIP_SHIFT +: HEIGHT_BITS];
  assign blend = BLEND_BITS'(s1_center_q) * BLEND_BITS'(FULL_SCALE - strength_i)
               + BLEND_BITS'(avg) * BLEND_BITS'(strength_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      valid_q    <= 1'b0;
    end else begin
      s1_valid_q <= res_i.valid;
      valid_q    <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_i.valid) begin
      s1_prod_q   <= PROD_BITS'(res_i.sum) * PROD_BITS'(recip(res_i.count));
      s1_center_q <= res_i.center;
      s1_count_q  <= res_i.count;
      s1_oor_q    <= res_i.oor;
    end
    if (s1_valid_q) begin
      if (s1_oor_q) begin
        height_q <= '0;
        count_q  <= '0;
      end else begin
        height_q <= OUT_BITS'(blend >> BLEND_SHIFT);
        count_q  <= s1_count_q;
      end
      oor_q <= s1_oor_q;
    end
  end

  assign busy_o   = s1_valid_q;
  assign valid_o  = valid_q;
  assign height_o = height_q;
  assign count_o  = count_q;
  assign oor_o    = oor_q;

endmodule

// ===== hw/rtl/neighborhood_blend_smoother.sv =====
// Top level of the 3x3 neighborhood height smoother with its register port.
`timescale 1ns / 1ps

// The block holds a 128 by 128 grid of 16-bit heights in one single-port RAM
// (row-major, stride 128). An item is taken when start is high and busy is
// low. A load (operation 0) writes height_in at (column, row) in the cycle it
// is taken, gives no result and keeps busy low, so loads can run at one per
// cycle while no query holds busy high. A query (operation 1) reads the nine
// cells around (column, row) one per cycle through the RAM port, skipping
// cells outside the configured grid, then divides the sum by the count with a
// reciprocal multiply and blends the average with the center height as
// (h*(256-s) + avg*s) / 256. A query inside the grid runs the nine RAM reads,
// the read register and two pipeline stages before its result strobe; one
// outside the grid skips the reads. The next item can be taken in the cycle
// the result strobe is high. The result is on the ports for exactly one cycle
// while result_valid_o is high, and the receiver cannot stall it, so it must
// take every result transfer as it comes. The user must write registers
// through the APB port only while the block is idle; the block does not
// enforce this. Strength is at 0x0, grid_width at 0x4 and grid_height at 0x8;
// strength saturates at 256 and each grid size at 128. No reset pass is run
// over the RAM, so a cell must be loaded before any query that reads it.

module neighborhood_blend_smoother import nbs_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Configuration port.
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [PADDR_BITS-1:0]  paddr,
  input  logic [PDATA_BITS-1:0]  pwdata,
  output logic [PDATA_BITS-1:0]  prdata,
  output logic                   pready,
  // Item handshake.
  input  logic                   start,
  output logic                   busy,
  input  logic                   operation_i,
  input  logic [COORD_BITS-1:0]  column_i,
  input  logic [COORD_BITS-1:0]  row_i,
  input  logic [OUT_BITS-1:0]    height_in_i,
  // Result strobe and fields.
  output logic                   result_valid_o,
  output logic [OUT_BITS-1:0]    smoothed_height_o,
  output logic [CNT_BITS-1:0]    neighbors_used_o,
  output logic                   out_of_range_o
);

  logic [STR_BITS-1:0]    strength_q;
  logic [GRID_BITS-1:0]   grid_width_q, grid_height_q;
  logic [STR_BITS-1:0]    strength_sat;
  logic [GRID_BITS-1:0]   gw_sat, gh_sat;

  logic                   cfg_write, accept, load_we;
  gth_cmd_t               cmd;
  gth_res_t               gth_res;
  logic                   gth_busy, blend_busy;
  logic                   ram_re, ram_en;
  logic [ADDR_BITS-1:0]   gth_addr, ram_addr;
  logic [HEIGHT_BITS-1:0] ram_rdata;

  // Register file. Writes beyond the three registers are dropped.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strength_q    <= STR_RESET;
      grid_width_q  <= GRID_MAX;
      grid_height_q <= GRID_MAX;
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        REG_STRENGTH:    strength_q    <= pwdata[STR_BITS-1:0];
        REG_GRID_WIDTH:  grid_width_q  <= pwdata[GRID_BITS-1:0];
        REG_GRID_HEIGHT: grid_height_q <= pwdata[GRID_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_STRENGTH:    prdata = PDATA_BITS'(strength_q);
      REG_GRID_WIDTH:  prdata = PDATA_BITS'(grid_width_q);
      REG_GRID_HEIGHT: prdata = PDATA_BITS'(grid_height_q);
      default:         prdata = '0;
    endcase
  end

  // Saturated views of the registers used by the datapath.
  assign strength_sat = (strength_q > FULL_SCALE) ? FULL_SCALE : strength_q;
  assign gw_sat       = (grid_width_q > GRID_MAX) ? GRID_MAX : grid_width_q;
  assign gh_sat       = (grid_height_q > GRID_MAX) ? GRID_MAX : grid_height_q;

  // Item transfer. Busy covers a query from its transfer until the result
  // leaves the first blend stage, which also keeps loads off the RAM port
  // while the sequencer reads it.
  assign busy      = gth_busy || blend_busy;
  assign accept    = start && !busy;
  assign load_we   = accept && (operation_i == OP_LOAD);
  assign cmd.start = accept && (operation_i == OP_QUERY);
  assign cmd.col   = column_i;
  assign cmd.row   = row_i;

  // The single RAM port is shared: a load writes, the sequencer reads.
  assign ram_en   = load_we || ram_re;
  assign ram_addr = load_we ? {row_i[DIM_BITS-1:0], column_i[DIM_BITS-1:0]} : gth_addr;

  nbs_height_ram #(
    .Depth (DEPTH),
    .Width (HEIGHT_BITS)
  ) u_ram (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (load_we),
    .addr_i  (ram_addr),
    .wdata_i (HEIGHT_BITS'(height_in_i)),
    .rdata_o (ram_rdata)
  );

  nbs_gather u_gather (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .gw_i        (gw_sat),
    .gh_i        (gh_sat),
    .ram_re_o    (ram_re),
    .ram_addr_o  (gth_addr),
    .ram_rdata_i (ram_rdata),
    .res_o       (gth_res),
    .busy_o      (gth_busy)
  );

  nbs_blend u_blend (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .res_i      (gth_res),
    .strength_i (strength_sat),
    .busy_o     (blend_busy),
    .valid_o    (result_valid_o),
    .height_o   (smoothed_height_o),
    .count_o    (neighbors_used_o),
    .oor_o      (out_of_range_o)
  );

endmodule
